### rtl/plfb_pkg.sv
package plfb_pkg;

    localparam int PAGES_DEF  = 8;
    localparam int COLS       = 128;
    localparam int COL_W      = 7;
    localparam int PG_W       = 3;
    localparam int Q_DEPTH    = 2;
    localparam int FONT_FIRST = 32;
    localparam int FONT_COUNT = 100;

    localparam logic [7:0] LCD_PAGE_CMD  = 8'hB0;
    localparam logic [7:0] LCD_COLH_CMD  = 8'h10;
    localparam logic [7:0] LCD_COLL_MASK = 8'h0F;

    typedef enum logic [1:0] {
        CMD_PIXEL = 2'd0,
        CMD_POS   = 2'd1,
        CMD_CHAR  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_SET    = 2'd1,
        OP_INVERT = 2'd2,
        OP_KEEP   = 2'd3
    } t_pix_op;

    // One decoded command, as it waits between front and back.
    typedef struct packed {
        t_cmd              cmd;
        logic [PG_W-1:0]   page;
        logic [COL_W-1:0]  col;
        logic [2:0]        bitpos;
        t_pix_op           op;
        logic [39:0]       glyph;   // column 0 in bits 39:32
    } t_item;

    typedef struct packed {
        logic clearing;
        logic emitting;
    } t_back_status;

    localparam logic [39:0] FONT_ROM [FONT_COUNT] = '{
        40'h0000000000, 40'h00004F0000, 40'h0007000700,
        40'h147F147F14, 40'h242A7F2A12, 40'h2313086462,
        40'h3649552240, 40'h0005030000, 40'h001C224100,
        40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
        40'h0050300000, 40'h0808080808, 40'h0060600000,
        40'h2010080402,
        40'h3E5149453E, 40'h00427F4000, 40'h4261514946,
        40'h2141454B31, 40'h1814127F10, 40'h2745454539,
        40'h3C4A494930, 40'h0171090503, 40'h3649494936,
        40'h064949291E,
        40'h0036360000, 40'h0056360000, 40'h0814224100,
        40'h1414141414, 40'h0041221408, 40'h020151093E,
        40'h324979413E,
        40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
        40'h7F4141221C, 40'h7F49494941, 40'h7F09090901,
        40'h3E4149493A, 40'h7F0808087F, 40'h00417F4100,
        40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
        40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
        40'h7F09090906, 40'h3E4151215E, 40'h7F09192946,
        40'h4649494931, 40'h01017F0101, 40'h3F4040403F,
        40'h1F2040201F, 40'h3F4070403F, 40'h6314081463,
        40'h0708700807, 40'h6151494543,
        40'h007F414100, 40'h0204081020, 40'h0041417F00,
        40'h0402010204, 40'h4040404040, 40'h0001020400,
        40'h2054545478, 40'h7F44444438, 40'h3844444420,
        40'h384444487F, 40'h3854545418, 40'h087E090102,
        40'h0C5252523E, 40'h7F08040478, 40'h00447D4000,
        40'h2040443D00, 40'h7F10284400, 40'h00417F4000,
        40'h7C04180478, 40'h7C08040478, 40'h3844444438,
        40'h7C14141408, 40'h081414187C, 40'h7C08040408,
        40'h4854545420, 40'h043F444020, 40'h3C4040207C,
        40'h1C2040201C, 40'h3C4020403C, 40'h4428102844,
        40'h0C5050503C, 40'h4464544C44,
        40'h0008364100, 40'h00007F0000, 40'h0041360800,
        40'h0C041C1018, 40'h0000000000,
        40'h08082A1C08, 40'h081C2A0808, 40'h0705070000,
        40'h0000000000
    };

    // Glyph of a character; codes without a glyph give a blank cell.
    function automatic logic [39:0] glyph_of(input logic [7:0] code);
        logic [7:0] offs;
        offs = code - 8'(FONT_FIRST);
        if (code >= 8'(FONT_FIRST) && code < 8'(FONT_FIRST + FONT_COUNT)) begin
            return FONT_ROM[offs[6:0]];
        end
        return 40'h0;
    endfunction

    // Fold a page number into 0..pages-1 by repeated subtraction.
    function automatic logic [PG_W-1:0] page_mod(input logic [PG_W-1:0] page,
                                                 input logic [3:0] pages);
        logic [3:0] v;
        v = {1'b0, page};
        for (int k = 0; k < 8; k++) begin
            if (v >= pages) begin
                v = v - pages;
            end
        end
        return v[PG_W-1:0];
    endfunction

endpackage

### rtl/plfb_queue.sv
module plfb_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  plfb_pkg::t_item i_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output plfb_pkg::t_item o_item
);
    import plfb_pkg::*;

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    t_item              r_mem [Q_DEPTH];
    logic [PTR_W-1:0]   r_wr, n_wr;
    logic [PTR_W-1:0]   r_rd, n_rd;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd];

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (do_push) begin
            n_wr = (r_wr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

endmodule

### rtl/plfb_front.sv
module plfb_front #(
    parameter int PAGES = plfb_pkg::PAGES_DEF
) (
    input  logic            i_in_valid,
    input  logic [1:0]      i_cmd,
    input  logic [6:0]      i_column,
    input  logic [5:0]      i_row,
    input  logic [1:0]      i_pixel_op,
    input  logic [2:0]      i_text_page,
    input  logic [7:0]      i_char_code,
    input  logic            i_full,
    input  logic            i_clearing,
    output logic            o_in_ready,
    output logic            o_push,
    output plfb_pkg::t_item o_item
);
    import plfb_pkg::*;

    t_cmd cmd;

    assign cmd        = t_cmd'(i_cmd);
    assign o_in_ready = !i_full && !i_clearing;
    // Drop the no-op command right here: it is accepted but never queued.
    assign o_push     = i_in_valid && o_in_ready && (cmd != CMD_NONE);

    always_comb begin
        o_item.cmd    = cmd;
        o_item.col    = i_column;
        o_item.bitpos = i_row[2:0];
        o_item.op     = t_pix_op'(i_pixel_op);
        o_item.glyph  = glyph_of(i_char_code);
        if (cmd == CMD_POS) begin
            o_item.page = page_mod(i_text_page, 4'(PAGES));
        end else begin
            o_item.page = page_mod(i_row[5:3], 4'(PAGES));
        end
    end

endmodule

### rtl/plfb_back.sv
module plfb_back #(
    parameter int PAGES = plfb_pkg::PAGES_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_q_valid,
    input  plfb_pkg::t_item        i_q_item,
    output logic                   o_pop,
    output plfb_pkg::t_back_status o_status,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [7:0]             o_lcd_byte,
    output logic                   o_is_data,
    output logic                   o_last
);
    import plfb_pkg::*;

    localparam int DEPTH = PAGES * COLS;
    localparam int PW    = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int AW    = PW + COL_W;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_MOD   = 4'b0100,
        S_EMIT  = 4'b1000
    } t_state;

    logic [7:0]     r_mem [DEPTH];
    logic [7:0]     r_rd_data;

    t_state         r_state, n_state;
    logic [AW-1:0]  r_clr, n_clr;
    logic [AW-1:0]  r_ptr, n_ptr;
    logic [2:0]     r_cnt, n_cnt;
    t_item          r_item;
    logic [7:0]     r_data;
    logic           r_out_valid;
    logic [7:0]     r_out_byte;
    logic           r_out_data;
    logic           r_out_last;

    logic           fire;
    logic           wr_en;
    logic [AW-1:0]  wr_addr;
    logic [7:0]     wr_data;
    logic [AW-1:0]  rd_addr;
    logic [7:0]     mask;
    logic [7:0]     mod_data;
    logic [7:0]     glyph_byte;
    logic [7:0]     e_byte;
    logic           e_data;
    logic           e_last;

    assign o_pop   = (r_state == S_IDLE) && i_q_valid;
    assign fire    = (r_state == S_EMIT) && (!r_out_valid || i_out_ready);
    assign rd_addr = {i_q_item.page[PW-1:0], i_q_item.col};

    assign o_status.clearing = (r_state == S_CLEAR);
    assign o_status.emitting = (r_state == S_EMIT);

    assign o_out_valid = r_out_valid;
    assign o_lcd_byte  = r_out_byte;
    assign o_is_data   = r_out_data;
    assign o_last      = r_out_last;

    // Read-modify-write of one pixel bit.
    always_comb begin
        mask = 8'd1 << r_item.bitpos;
        unique case (r_item.op)
            OP_CLEAR:  mod_data = r_rd_data & ~mask;
            OP_SET:    mod_data = r_rd_data | mask;
            OP_INVERT: mod_data = r_rd_data ^ mask;
            OP_KEEP:   mod_data = r_rd_data;
        endcase
    end

    always_comb begin
        unique case (r_cnt)
            3'd0:    glyph_byte = r_item.glyph[39:32];
            3'd1:    glyph_byte = r_item.glyph[31:24];
            3'd2:    glyph_byte = r_item.glyph[23:16];
            3'd3:    glyph_byte = r_item.glyph[15:8];
            3'd4:    glyph_byte = r_item.glyph[7:0];
            default: glyph_byte = 8'h00;
        endcase
    end

    // Byte sequence of the current command.
    always_comb begin
        e_byte = 8'h00;
        e_data = 1'b0;
        e_last = 1'b0;
        unique case (r_item.cmd)
            CMD_PIXEL, CMD_POS: begin
                unique case (r_cnt)
                    3'd0:    e_byte = LCD_PAGE_CMD | {5'd0, r_item.page};
                    3'd1:    e_byte = LCD_COLH_CMD | {5'd0, r_item.col[6:4]};
                    3'd2:    e_byte = {1'b0, r_item.col} & LCD_COLL_MASK;
                    default: e_byte = r_data;
                endcase
                if (r_item.cmd == CMD_PIXEL) begin
                    e_data = (r_cnt == 3'd3);
                    e_last = (r_cnt == 3'd3);
                end else begin
                    e_last = (r_cnt == 3'd2);
                end
            end
            CMD_CHAR: begin
                e_byte = glyph_byte;
                e_data = 1'b1;
                e_last = (r_cnt == 3'd5);
            end
            CMD_NONE: begin
                e_last = 1'b1;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_clr   = r_clr;
        n_ptr   = r_ptr;
        n_cnt   = r_cnt;
        wr_en   = 1'b0;
        wr_addr = r_clr;
        wr_data = 8'h00;
        unique case (r_state)
            S_CLEAR: begin
                wr_en = 1'b1;
                n_clr = r_clr + 1'b1;
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                n_cnt = 3'd0;
                if (i_q_valid) begin
                    if (i_q_item.cmd == CMD_PIXEL) begin
                        n_state = S_MOD;
                    end else begin
                        n_state = S_EMIT;
                    end
                    if (i_q_item.cmd == CMD_POS) begin
                        n_ptr = rd_addr;
                    end
                end
            end
            S_MOD: begin
                wr_en   = 1'b1;
                wr_addr = {r_item.page[PW-1:0], r_item.col};
                wr_data = mod_data;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (fire) begin
                    n_cnt = r_cnt + 1'b1;
                    if (r_item.cmd == CMD_CHAR) begin
                        wr_en   = 1'b1;
                        wr_addr = r_ptr;
                        wr_data = e_byte;
                        n_ptr   = (r_ptr == AW'(DEPTH - 1)) ? '0 : r_ptr + 1'b1;
                    end
                    if (e_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_q_item;
        end
        if (r_state == S_MOD) begin
            r_data <= mod_data;
        end
        if (fire) begin
            r_out_byte <= e_byte;
            r_out_data <= e_data;
            r_out_last <= e_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_ptr       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_ptr   <= n_ptr;
            r_cnt   <= n_cnt;
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

### rtl/page_lcd_frame_buffer_draw.sv
// Draw engine for a page-mode monochrome LCD: keeps a PAGES x 128 byte frame
// store (bit k of a byte is pixel row page*8+k) and a text write pointer, and
// turns each command into the byte stream a page-mode controller needs to
// mirror the change. Draw pixel yields page, column-high and column-low
// commands then the updated data byte; set text position yields the three
// commands; put character writes and sends five glyph columns and a blank
// one. The last output byte of every command has o_last set; command 3 is
// accepted and ignored. After reset every byte of the frame store is cleared
// to zero, and o_in_ready stays low until the clearing pass is done.
// A two-entry command queue lets the input side run ahead of the output.
// Draw pixel passes through the executor as queue pop with store read, bit
// update and write back, then four bytes; set text position and put
// character pop and then send their bytes. The output register takes one
// byte per cycle while the output is taken, and stalls otherwise.
module page_lcd_frame_buffer_draw #(
    parameter int PAGES = plfb_pkg::PAGES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // command transactions
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_cmd,
    input  logic [6:0] i_column,
    input  logic [5:0] i_row,
    input  logic [1:0] i_pixel_op,
    input  logic [2:0] i_text_page,
    input  logic [7:0] i_char_code,
    // display byte transactions
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_lcd_byte,
    output logic       o_is_data,
    output logic       o_last
);
    import plfb_pkg::*;

    t_item        push_item;
    t_item        q_item;
    logic         push;
    logic         q_full;
    logic         q_valid;
    logic         pop;
    t_back_status status;

    // Front: accept, decode, fold pages, look up glyphs.
    plfb_front #(
        .PAGES (PAGES)
    ) u_front (
        .i_in_valid  (i_in_valid),
        .i_cmd       (i_cmd),
        .i_column    (i_column),
        .i_row       (i_row),
        .i_pixel_op  (i_pixel_op),
        .i_text_page (i_text_page),
        .i_char_code (i_char_code),
        .i_full      (q_full),
        .i_clearing  (status.clearing),
        .o_in_ready  (o_in_ready),
        .o_push      (push),
        .o_item      (push_item)
    );

    // Hold decoded commands until the executor is free.
    plfb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    // Back: frame store, text pointer and byte sequencing.
    plfb_back #(
        .PAGES (PAGES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item),
        .o_pop       (pop),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_lcd_byte  (o_lcd_byte),
        .o_is_data   (o_is_data),
        .o_last      (o_last)
    );

`ifndef SYNTHESIS
    // No command is taken while the frame store is being cleared.
    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.clearing |-> !o_in_ready)
        else $error("command accepted during clearing pass");

    // A byte that is not the last of its command is followed at once.
    a_burst_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_last) |=> o_out_valid)
        else $error("gap inside a command's byte burst");

    // A non-final byte is only on the output while its command is still running.
    a_mid_emitting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_last) |-> status.emitting)
        else $error("executor left a command before its last byte");

    // A final command byte is always the column-low command.
    a_last_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last && !o_is_data) |-> (o_lcd_byte[7:4] == 4'h0))
        else $error("final command byte is not a column-low command");
`endif

endmodule
